// ----- src/nearest_segment_pick_unit_macros.svh -----
// Assertion macros shared by the checker.
`ifndef NEAREST_SEGMENT_PICK_UNIT_MACROS_SVH
`define NEAREST_SEGMENT_PICK_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define NSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also looks across reset
`define NSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/nsp_pkg.sv -----
// ----------------------------------------------------------------------------
// nsp_pkg
// Types and constants shared by the nearest segment pick unit.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int COORD_BITS   = 24;     // significant coordinate bits
  localparam int MAX_SEGMENTS = 65536;  // segments counted per query
  localparam int FIELD_W      = 24;     // coordinate field width
  localparam int DIST_W       = 51;     // max_dist_sq width
  localparam int IDX_W        = 16;
  localparam int CNT_W        = 17;
  localparam int FRAC         = 24;     // fraction bits of t
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int IN_DATA_W    = 200;
  localparam int OUT_DATA_W   = 16;

  typedef logic signed [FIELD_W-1:0] coord_t;

  // One classified segment, front to back
  typedef struct packed {
    coord_t              qx;
    coord_t              qy;
    coord_t              sx;
    coord_t              sy;
    coord_t              ex;
    coord_t              ey;
    logic [DIST_W-1:0]   max_d;
    logic [IDX_W-1:0]    pos;
    logic                compute;   // counted and marked valid
    logic                last;
    logic                too_many;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic             too_many;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_CLS, B_DIV, B_PROJ, B_SQ, B_UPD
  } back_state_e;

endpackage

// ----- src/nsp_front.sv -----
// ----------------------------------------------------------------------------
// nsp_front
// Unpacks input beats, counts segment positions and flags overflow.
// ----------------------------------------------------------------------------
module nsp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // query_x, query_y, max_dist_sq, start_x, start_y, end_x, end_y, zero pad
  input  logic [nsp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic                                s_axis_tuser,  // seg_ok
  input  logic                                s_axis_tlast,
  input  logic                                full_i,
  output logic                                push_o,
  output nsp_pkg::item_t                      item_o
);
  import nsp_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             counted;

  // sign-extend the significant coordinate bits of a field
  function automatic coord_t coord_of(input logic [FIELD_W-1:0] f);
    coord_of = coord_t'($signed(f[COORD_BITS-1:0]));
  endfunction

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // classify the beat
  always_comb begin
    counted = cnt_q < CNT_W'(MAX_SEGMENTS);
    cnt_inc = counted ? cnt_q + CNT_W'(1) : CNT_W'(MAX_SEGMENTS + 1);
    item_o.qx       = coord_of(s_axis_tdata[23:0]);
    item_o.qy       = coord_of(s_axis_tdata[47:24]);
    item_o.max_d    = s_axis_tdata[98:48];
    item_o.sx       = coord_of(s_axis_tdata[122:99]);
    item_o.sy       = coord_of(s_axis_tdata[146:123]);
    item_o.ex       = coord_of(s_axis_tdata[170:147]);
    item_o.ey       = coord_of(s_axis_tdata[194:171]);
    item_o.pos      = cnt_q[IDX_W-1:0];
    item_o.compute  = counted && s_axis_tuser;
    item_o.last     = s_axis_tlast;
    item_o.too_many = cnt_inc > CNT_W'(MAX_SEGMENTS);
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = s_axis_tlast ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/nsp_fifo.sv -----
// ----------------------------------------------------------------------------
// nsp_fifo
// Short queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module nsp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nsp_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output nsp_pkg::item_t  item_o
);
  import nsp_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   fill_q;

  assign full_o  = fill_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign valid_o = fill_q != '0;
  assign item_o  = mem_q[rd_q];

  // payload store
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_AW'(1);
      if (pop_i)  rd_q <= rd_q + FIFO_AW'(1);
      fill_q <= fill_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

endmodule

// ----- src/nsp_back.sv -----
// ----------------------------------------------------------------------------
// nsp_back
// Point-to-segment distance on one shared multiplier and a bit-serial
// divider, running minimum and result register.
// ----------------------------------------------------------------------------
module nsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  nsp_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output nsp_pkg::result_t  res_o,
  input  logic              res_ready_i
);
  import nsp_pkg::*;

  back_state_e        state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;
  item_t              it_q, it_d;
  logic [50:0]        len2_q, len2_d, rem_q, rem_d, r2;
  logic signed [50:0] dot_q, dot_d;
  logic [FRAC:0]      t_q, t_d;
  logic signed [25:0] dx_q, dx_d, dy_q, dy_d, proj, pnt, dq;
  logic [51:0]        d2_q, d2_d, best_q, best_d, nb_best;
  logic [IDX_W-1:0]   pos_q, pos_d, nb_pos;
  logic               seen_q, seen_d, nb_seen, upd;
  logic               cand_q, cand_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;
  logic signed [24:0] cx, cy, ax, ay;
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // segment and offset vectors
  assign cx = 25'(it_q.ex) - 25'(it_q.sx);
  assign cy = 25'(it_q.ey) - 25'(it_q.sy);
  assign ax = 25'(it_q.qx) - 25'(it_q.sx);
  assign ay = 25'(it_q.qy) - 25'(it_q.sy);

  // shared multiplier operand select
  always_comb begin
    mul_a = 26'(cx);
    mul_b = 26'(cx);
    case (state_q)
      B_MUL: begin
        mul_a = cnt_q[1] ? (cnt_q[0] ? 26'(ay) : 26'(ax))
                         : (cnt_q[0] ? 26'(cy) : 26'(cx));
        mul_b = cnt_q[0] ? 26'(cy) : 26'(cx);
      end
      B_PROJ: begin
        mul_a = $signed({1'b0, t_q});
        mul_b = cnt_q[0] ? 26'(cy) : 26'(cx);
      end
      B_SQ: begin
        mul_a = cnt_q[0] ? dy_q : dx_q;
        mul_b = cnt_q[0] ? dy_q : dx_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // projected point and offset, floor by arithmetic shift
  assign proj = 26'(mul_p >>> FRAC);
  assign pnt  = (cnt_q[0] ? 26'(it_q.sy) : 26'(it_q.sx)) + proj;
  assign dq   = (cnt_q[0] ? 26'(it_q.qy) : 26'(it_q.qx)) - pnt;

  assign r2 = {rem_q[49:0], 1'b0};

  // running minimum with the current candidate folded in
  assign upd     = it_q.compute && cand_q && (!seen_q || d2_q < best_q);
  assign nb_seen = seen_q || upd;
  assign nb_best = upd ? d2_q : best_q;
  assign nb_pos  = upd ? it_q.pos : pos_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    it_d    = it_q;
    len2_d  = len2_q;
    dot_d   = dot_q;
    rem_d   = rem_q;
    t_d     = t_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    d2_d    = d2_q;
    best_d  = best_q;
    pos_d   = pos_q;
    seen_d  = seen_q;
    cand_d  = cand_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          it_d    = item_i;
          cand_d  = 1'b0;
          cnt_d   = '0;
          state_d = item_i.compute ? B_MUL : B_UPD;
        end
      end
      B_MUL: begin
        case (cnt_q[1:0])
          2'd0:    len2_d = 51'(mul_p);
          2'd1:    len2_d = len2_q + 51'(mul_p);
          2'd2:    dot_d  = 51'(mul_p);
          default: dot_d  = dot_q + 51'(mul_p);
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = B_CLS;
        end
      end
      B_CLS: begin
        cnt_d = '0;
        if (len2_q == '0) begin
          state_d = B_UPD;
        end else if (dot_q <= 0) begin
          t_d     = '0;
          state_d = B_PROJ;
        end else if (unsigned'(dot_q) >= len2_q) begin
          t_d     = (FRAC+1)'(1) << FRAC;
          state_d = B_PROJ;
        end else begin
          rem_d   = unsigned'(dot_q);
          t_d     = '0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (r2 >= len2_q) begin
          rem_d = r2 - len2_q;
          t_d   = {t_q[FRAC-1:0], 1'b1};
        end else begin
          rem_d = r2;
          t_d   = {t_q[FRAC-1:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(FRAC - 1)) begin
          cnt_d   = '0;
          state_d = B_PROJ;
        end
      end
      B_PROJ: begin
        if (cnt_q[0]) begin
          dy_d    = dq;
          cnt_d   = '0;
          state_d = B_SQ;
        end else begin
          dx_d  = dq;
          cnt_d = 5'd1;
        end
      end
      B_SQ: begin
        if (cnt_q[0]) begin
          d2_d    = d2_q + 52'(mul_p);
          cand_d  = 1'b1;
          state_d = B_UPD;
        end else begin
          d2_d  = 52'(mul_p);
          cnt_d = 5'd1;
        end
      end
      B_UPD: begin
        if (!it_q.last) begin
          seen_d  = nb_seen;
          best_d  = nb_best;
          pos_d   = nb_pos;
          state_d = B_IDLE;
        end else if (!out_valid_q || res_ready_i) begin
          out_d.found    = nb_seen && nb_best <= 52'(it_q.max_d);
          out_d.idx      = (nb_seen && nb_best <= 52'(it_q.max_d)) ? nb_pos : '0;
          out_d.too_many = it_q.too_many;
          out_valid_d    = 1'b1;
          seen_d  = 1'b0;
          best_d  = '0;
          pos_d   = '0;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    len2_q <= len2_d;
    dot_q  <= dot_d;
    rem_q  <= rem_d;
    t_q    <= t_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    d2_q   <= d2_d;
    cand_q <= cand_d;
    out_q  <= out_d;
  end

endmodule

// ----- src/nearest_segment_pick_unit.sv -----
// Accept to result beat: the queue registers each beat, then the back end takes
// an invalid or uncounted last segment straight to B_UPD, a zero-length one
// through B_MUL and B_CLS, a clamped one also through B_PROJ and B_SQ, and one
// needing the projection divide also through B_DIV. The back end takes one
// segment at a time, on the 24-step serial divider and single shared multiplier.
// Reset (asynchronous, active low) clears counts, the minimum and the queue.
// ----------------------------------------------------------------------------
// nearest_segment_pick_unit
// Streams segments of a query and reports the nearest one to the query point.
// ----------------------------------------------------------------------------
module nearest_segment_pick_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_x, query_y, max_dist_sq, start_x, start_y, end_x, end_y, zero pad
  input  logic [nsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,  // seg_ok
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [nsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // seg_index
  output logic [1:0]                        m_axis_tuser   // found, too_many
);
  import nsp_pkg::*;

  item_t   f_item, q_item;
  logic    push, full, q_valid, pop;
  result_t res;

  nsp_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .full_i (full),
    .push_o (push),
    .item_o (f_item)
  );

  nsp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  nsp_back u_back (
    .clk_i, .rst_ni,
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res.idx;
  assign m_axis_tuser = {res.too_many, res.found};

endmodule

// ----- src/nsp_checker.sv -----
// ----------------------------------------------------------------------------
// nsp_checker
// Port-level checks on the nearest segment pick unit.
// ----------------------------------------------------------------------------
`include "nearest_segment_pick_unit_macros.svh"

module nsp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [nsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  // a stalled result beat holds
  `NSP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat dropped or changed while stalled")

  // not found reports index zero
  `NSP_ASSERT(a_nf_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "index set without a hit")

  // no result straight out of reset
  `NSP_ASSERT_RST(a_rst_idle, $past(!rst_ni) |-> !m_axis_tvalid, "result valid after reset")

endmodule

bind nearest_segment_pick_unit nsp_checker u_nsp_checker (.*);

// ----- sim/nearest_segment_pick_unit_test.sv -----
// ----------------------------------------------------------------------------
// nearest_segment_pick_unit_test
// Streams segment queries into the pick unit with random gaps and stalls on
// both sides. A scoreboard predicts every query result and compares it with
// the result beat. Covers clamping, skipped segments, ties and limits.
// ----------------------------------------------------------------------------
module nearest_segment_pick_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nsp_pkg::*;

  typedef struct {
    coord_t            qx, qy, sx, sy, ex, ey;
    logic [DIST_W-1:0] max_d;
    bit                ok, last;
  } seg_beat_t;

  typedef struct {
    bit               found;
    logic [IDX_W-1:0] idx;
    bit               too_many;
  } pick_t;

  // Nearest-segment predictor and store of pending query results
  class pick_scoreboard;
    pick_t       pending[$];
    longint      near_d2;
    int          near_pos;
    bit          near_seen;
    int          count;
    int          errors;

    function new();
      near_d2 = 0; near_pos = 0; near_seen = 0; count = 0; errors = 0;
    endfunction

    // floor of p / 2^24
    function longint floor24(longint p);
      if (p >= 0) return p >>> 24;
      return -((-p + 64'hFFFFFF) >>> 24);
    endfunction

    // squared distance to one segment; 0 returned in ok when degenerate
    function bit seg_d2(seg_beat_t b, output longint d2);
      longint qx, qy, sx, sy, cx, cy, ax, ay, len2, dot, t, r, px, py, dx, dy;
      qx = b.qx; qy = b.qy; sx = b.sx; sy = b.sy;
      cx = longint'(b.ex) - sx; cy = longint'(b.ey) - sy;
      ax = qx - sx; ay = qy - sy;
      len2 = cx * cx + cy * cy;
      dot  = ax * cx + ay * cy;
      d2 = 0;
      if (len2 <= 0) return 0;
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = 64'd1 << FRAC;
      else begin
        // restoring divide, 24 fraction bits
        r = dot; t = 0;
        for (int i = 0; i < FRAC; i++) begin
          r = r <<< 1; t = t <<< 1;
          if (r >= len2) begin
            r -= len2; t |= 1;
          end
        end
      end
      px = sx + floor24(t * cx);
      py = sy + floor24(t * cy);
      dx = qx - px; dy = qy - py;
      d2 = dx * dx + dy * dy;
      return 1;
    endfunction

    function void note_beat(seg_beat_t b);
      longint d2;
      pick_t  res;
      if (count < MAX_SEGMENTS) begin
        if (b.ok && seg_d2(b, d2)) begin
          if (!near_seen || d2 < near_d2) begin
            near_d2 = d2; near_pos = count; near_seen = 1;
          end
        end
        count++;
      end else count = MAX_SEGMENTS + 1;
      if (b.last) begin
        res.found    = near_seen && (near_d2 <= longint'({13'd0, b.max_d}));
        res.idx      = res.found ? near_pos[IDX_W-1:0] : '0;
        res.too_many = count > MAX_SEGMENTS;
        pending = {pending, res};
        near_d2 = 0; near_pos = 0; near_seen = 0; count = 0;
      end
    endfunction

    function void check_beat(bit found, logic [IDX_W-1:0] idx, bit too_many);
      pick_t e;
      if (pending.size() == 0) begin
        $error("result beat with no query pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found); errors++;
      end
      if (idx !== e.idx) begin
        $error("seg_index: expected %0d, got %0d", e.idx, idx); errors++;
      end
      if (too_many !== e.too_many) begin
        $error("too_many: expected %0d, got %0d", e.too_many, too_many); errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 0;
  logic                  s_axis_tlast = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  pick_scoreboard sb = new();
  bit  hold_req = 0;   // receiver long hold-off
  bit  fast = 0;       // no idling on either side
  int  quiet = 0;

  nearest_segment_pick_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic int draw_gap();
    if (fast || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 0;
        repeat (300) @(negedge clk_i);
        hold_req = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready = 0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_beat(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
    end
  end

  // Offer one segment beat and wait for it to be taken
  task automatic send_seg(seg_beat_t b);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {5'd0, b.ey, b.ex, b.sy, b.sx, b.max_d, b.qy, b.qx};
    s_axis_tuser  = b.ok;
    s_axis_tlast  = b.last;
    s_axis_tvalid = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(b);
  endtask

  task automatic seg(int qx, int qy, longint md, int sx, int sy, int ex, int ey,
                     bit ok, bit last);
    seg_beat_t b;
    b.qx = coord_t'(qx); b.qy = coord_t'(qy); b.max_d = md[DIST_W-1:0];
    b.sx = coord_t'(sx); b.sy = coord_t'(sy);
    b.ex = coord_t'(ex); b.ey = coord_t'(ey); b.ok = ok; b.last = last;
    send_seg(b);
  endtask

  function automatic int rand_coord(bit wide, int base);
    if (wide) return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
    return base + $urandom_range(0, 8000) - 4000;
  endfunction

  function automatic longint rand_limit();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return (64'd1 << DIST_W) - 1;
      2: return {$urandom, $urandom} & ((64'd1 << DIST_W) - 1);
      default: return {$urandom, $urandom} & ((64'd1 << $urandom_range(1, DIST_W)) - 1);
    endcase
  endfunction

  // One random query of n segments with shared query point
  task automatic random_query(int n);
    seg_beat_t b, prev;
    bit wide;
    int base;
    wide = ($urandom_range(0, 3) == 0);
    base = rand_coord(1, 0) >>> 1;
    b.qx = coord_t'(rand_coord(wide, base)); b.qy = coord_t'(rand_coord(wide, base));
    b.max_d = DIST_W'(rand_limit());
    for (int i = 0; i < n; i++) begin
      b.sx = coord_t'(rand_coord(wide, base)); b.sy = coord_t'(rand_coord(wide, base));
      b.ex = coord_t'(rand_coord(wide, base)); b.ey = coord_t'(rand_coord(wide, base));
      b.ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 19) == 0) begin
        b.ex = b.sx; b.ey = b.sy;   // zero length
      end
      if (i > 0 && $urandom_range(0, 19) == 0) begin
        b.sx = prev.sx; b.sy = prev.sy; b.ex = prev.ex; b.ey = prev.ey;  // tie
      end
      b.last = (i == n - 1);
      send_seg(b);
      prev = b;
    end
  endtask

  initial begin
    localparam longint MAXD = (64'd1 << DIST_W) - 1;
    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;
    int sent;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // Directed: clamp ends, projection, skips, ties, limits, extremes
    seg(0, 4096, MAXD, 0, 0, 8192, 0, 1, 1);               // point above start, clamps to start
    seg(-4096, 0, MAXD, 0, 0, 8192, 0, 1, 0);              // clamps to start
    seg(20000, 0, MAXD, 0, 0, 8192, 0, 1, 1);              // clamps to end
    seg(0, 0, MAXD, 100, 100, 100, 100, 1, 0);             // zero length
    seg(0, 0, MAXD, 0, 10, 50, 10, 0, 0);                  // invalid
    seg(0, 0, MAXD, -50, 20, 50, 20, 1, 0);
    seg(0, 0, MAXD, -50, 20, 50, 20, 1, 1);                // tie keeps first
    seg(0, 0, MAXD, 5, 5, 5, 5, 1, 1);                     // nothing usable
    seg(0, 0, 0, 0, 0, 4096, 0, 1, 1);                     // on segment, limit 0
    seg(0, 0, 0, 0, 1, 4096, 1, 1, 1);                     // just outside limit 0
    seg(CMIN, CMIN, MAXD, CMAX, CMAX, CMAX, CMIN, 1, 1);
    seg(CMAX, CMAX, MAXD, CMIN, CMIN, CMIN, CMAX, 1, 0);
    seg(CMAX, CMIN, MAXD, CMIN, CMIN, CMAX, CMAX, 1, 1);
    seg(CMAX, CMAX, 123456, CMIN, CMAX, CMAX, CMIN, 1, 1);
    seg(777, -333, 1 << 30, 1000, 1000, -1000, 999, 1, 0);
    seg(777, -333, 1 << 30, 700, -300, 900, -400, 1, 1);

    // Long hold-off on the result side while queries keep coming
    hold_req = 1;
    for (int i = 0; i < 12; i++) seg(i, i, MAXD, 0, 0, 4096, 4096, 1, 1);

    // Random queries
    sent = 0;
    while (sent < 620) begin
      int n;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      fast = ($urandom_range(0, 7) == 0);
      random_query(n);
      sent += n;
    end
    fast = 0;

    @(negedge clk_i) s_axis_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/nsp_pkg.sv
src/nsp_front.sv
src/nsp_fifo.sv
src/nsp_back.sv
src/nearest_segment_pick_unit.sv
src/nsp_checker.sv
sim/nearest_segment_pick_unit_test.sv
